>>> rtl/octave_perlin_noise_3d_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the octave Perlin noise core
// Shared property wrappers, clocked on clock, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef OCTAVE_PERLIN_NOISE_3D_CORE_ASSERT_SVH
`define OCTAVE_PERLIN_NOISE_3D_CORE_ASSERT_SVH

// Checked only while reset is low.
`define OPN3D_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checked at every edge, reset included.
`define OPN3D_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> rtl/opn3d_pkg.sv
// ----------------------------------------------------------------------------
// Octave Perlin noise package
// Widths, reset values, register indexes and the link carried between cells.
// ----------------------------------------------------------------------------
package opn3d_pkg;

   localparam int MAX_OCTAVES     = 8;
   localparam int COORD_FRAC_BITS = 16;
   localparam int FREQ_FRAC_BITS  = 24;
   localparam int FRAC_POS        = COORD_FRAC_BITS + FREQ_FRAC_BITS;
   localparam int PROD_W          = FRAC_POS + 8;

   localparam int COORD_W = 32;
   localparam int FREQ_W  = 32;
   localparam int SEED_W  = 32;
   localparam int OCT_W   = 4;
   localparam int PERS_W  = 17;
   localparam int OUT_W   = 16;

   localparam int HSEED_W = 24;
   localparam int CNT_W   = $clog2(MAX_OCTAVES + 1);
   localparam int AMP_W   = 16 + MAX_OCTAVES;
   localparam int NOISE_W = 19;
   localparam int WPROD_W = NOISE_W + AMP_W + 1;
   localparam int TOTAL_W = WPROD_W + $clog2(MAX_OCTAVES) + 1;
   localparam int ASUM_W  = AMP_W + $clog2(MAX_OCTAVES) + 1;
   localparam int QUO_W   = 17;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_NOISE_SEED     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OCTAVE_COUNT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PERSISTENCE    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_FREQUENCY = 2'd3;

   localparam logic [SEED_W-1:0] SEED_RST       = 32'd0;
   localparam logic [OCT_W-1:0]  OCT_RST        = 4'd4;
   localparam logic [PERS_W-1:0] PERS_RST       = 17'd32768;
   localparam logic [FREQ_W-1:0] BASE_FREQ_RST  = 32'd16777216;

   localparam logic [AMP_W-1:0] AMP_ONE   = AMP_W'(65536);
   localparam logic [31:0]      HASH_MULT = 32'd2654435761;
   localparam logic [16:0]      ONE_Q16   = 17'd65536;

   localparam logic [QUO_W-1:0] SAT_POS_MAG = 17'd32767;
   localparam logic [QUO_W-1:0] SAT_NEG_MAG = 17'd32768;
   localparam logic [OUT_W-1:0] SAT_POS     = 16'h7FFF;
   localparam logic [OUT_W-1:0] SAT_NEG     = 16'h8000;

   typedef struct packed {
      logic                       valid;
      logic [PROD_W-1:0]          px;
      logic [PROD_W-1:0]          py;
      logic [PROD_W-1:0]          pz;
      logic [HSEED_W-1:0]         seed;
      logic [CNT_W-1:0]           cnt;
      logic [AMP_W-1:0]           amp;
      logic signed [TOTAL_W-1:0]  total;
      logic [ASUM_W-1:0]          amp_sum;
   } link_type;

endpackage

>>> rtl/octave_perlin_noise_3d_core.sv
// ----------------------------------------------------------------------------
// Octave Perlin noise core
// Fractal 3D gradient noise over a row of octave cells and a divider.
// ----------------------------------------------------------------------------
// A point enters on the req_ stream (x, y, z in signed Q16.16) and one noise
// value leaves on the rsp_ stream in signed Q2.14, in the order of entry.
// The csr_ port sets seed, octave count, persistence and base frequency, one
// register per edge; it is written while no point is in flight, a rule for
// the user that the block does not enforce. One point is taken in every cycle
// while req_tready is high. The transfer edge loads the input multiply
// register; the point then passes nine stages in each of the eight octave
// cells, the divider (entry register, one quotient bit per stage, output
// register) and the output register. Octaves past the configured count add nothing.
// Reset clears all valid flags and loads the register reset values; the
// pipeline comes up empty and req_tready is high.
// When the receiver holds rsp_tready low, the next finished value goes to a
// skid register and the pipeline then stops, dropping req_tready, until the
// output register is taken.
module octave_perlin_noise_3d_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [95:0]                         req_tdata,  // coord_x, coord_y, coord_z
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [opn3d_pkg::OUT_W-1:0]         rsp_tdata,  // noise_value
   input  logic                                csr_wen,
   input  logic [opn3d_pkg::CSR_IDX_W-1:0]     csr_addr,
   input  logic [opn3d_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic [opn3d_pkg::SEED_W-1:0]  noise_seed_ff;
   logic [opn3d_pkg::OCT_W-1:0]   octave_count_ff;
   logic [opn3d_pkg::PERS_W-1:0]  persistence_ff;
   logic [opn3d_pkg::FREQ_W-1:0]  base_frequency_ff;

   logic                          en;
   logic [opn3d_pkg::CNT_W-1:0]   oct_n;
   logic signed [64:0]            prod [3];
   logic signed [opn3d_pkg::COORD_W-1:0] coord [3];
   opn3d_pkg::link_type           chain [opn3d_pkg::MAX_OCTAVES+1];
   opn3d_pkg::link_type           in_ff, in_in;

   logic                          pipe_valid;
   logic [opn3d_pkg::OUT_W-1:0]   pipe_value;
   logic                          out_valid_ff, out_valid_in;
   logic [opn3d_pkg::OUT_W-1:0]   out_data_ff, out_data_in;
   logic                          skid_valid_ff, skid_valid_in;
   logic [opn3d_pkg::OUT_W-1:0]   skid_data_ff, skid_data_in;
   logic                          take;

   always_ff @(posedge clock) begin
      if (reset) begin
         noise_seed_ff     <= opn3d_pkg::SEED_RST;
         octave_count_ff   <= opn3d_pkg::OCT_RST;
         persistence_ff    <= opn3d_pkg::PERS_RST;
         base_frequency_ff <= opn3d_pkg::BASE_FREQ_RST;
      end else if (csr_wen) begin
         unique case (csr_addr)
            opn3d_pkg::CSR_NOISE_SEED:
               noise_seed_ff <= csr_wdata[opn3d_pkg::SEED_W-1:0];
            opn3d_pkg::CSR_OCTAVE_COUNT:
               octave_count_ff <= csr_wdata[opn3d_pkg::OCT_W-1:0];
            opn3d_pkg::CSR_PERSISTENCE:
               persistence_ff <= csr_wdata[opn3d_pkg::PERS_W-1:0];
            opn3d_pkg::CSR_BASE_FREQUENCY:
               base_frequency_ff <= csr_wdata[opn3d_pkg::FREQ_W-1:0];
            default: ;
         endcase
      end
   end

   assign en         = !skid_valid_ff;
   assign req_tready = en;

   assign coord[0] = req_tdata[31:0];
   assign coord[1] = req_tdata[63:32];
   assign coord[2] = req_tdata[95:64];

   always_comb begin
      if (octave_count_ff == '0) begin
         oct_n = opn3d_pkg::CNT_W'(1);
      end else if (32'(octave_count_ff) > 32'(opn3d_pkg::MAX_OCTAVES)) begin
         oct_n = opn3d_pkg::CNT_W'(opn3d_pkg::MAX_OCTAVES);
      end else begin
         oct_n = opn3d_pkg::CNT_W'(octave_count_ff);
      end
      for (int ax = 0; ax < 3; ax++) begin
         prod[ax] = 65'(coord[ax]) * $signed({33'd0, base_frequency_ff});
      end
      in_in.valid   = req_tvalid;
      in_in.px      = prod[0][opn3d_pkg::PROD_W-1:0];
      in_in.py      = prod[1][opn3d_pkg::PROD_W-1:0];
      in_in.pz      = prod[2][opn3d_pkg::PROD_W-1:0];
      in_in.seed    = noise_seed_ff[opn3d_pkg::HSEED_W-1:0];
      in_in.cnt     = oct_n;
      in_in.amp     = opn3d_pkg::AMP_ONE;
      in_in.total   = '0;
      in_in.amp_sum = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_ff.valid <= 1'b0;
      end else if (en) begin
         in_ff <= in_in;
      end
   end

   assign chain[0] = in_ff;

   for (genvar i = 0; i < opn3d_pkg::MAX_OCTAVES; i++) begin : g_cell
      opn3d_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .en          (en),
         .persistence (persistence_ff),
         .link_i      (chain[i]),
         .link_o      (chain[i+1])
      );
   end

   opn3d_div u_div (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (chain[opn3d_pkg::MAX_OCTAVES].valid),
      .in_total   (chain[opn3d_pkg::MAX_OCTAVES].total),
      .in_amp_sum (chain[opn3d_pkg::MAX_OCTAVES].amp_sum),
      .out_valid  (pipe_valid),
      .out_value  (pipe_value)
   );

   assign take = out_valid_ff && rsp_tready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (take) begin
         out_valid_in = 1'b0;
      end
      if (skid_valid_ff) begin
         if (take) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (pipe_valid) begin
         if (!out_valid_ff || take) begin
            out_valid_in = 1'b1;
            out_data_in  = pipe_value;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = pipe_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

>>> rtl/opn3d_cell.sv
// ----------------------------------------------------------------------------
// Octave cell
// One octave of 3D gradient noise in nine pipeline stages: cell split and
// first hash, second hash, corner hashes with fade, gradients, three blend
// levels, amplitude weighting and accumulation into the link for the next cell.
// ----------------------------------------------------------------------------
module opn3d_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic [opn3d_pkg::PERS_W-1:0]    persistence,
   input  opn3d_pkg::link_type             link_i,
   output opn3d_pkg::link_type             link_o
);

   function automatic logic [7:0] hash8(input logic [9:0] idx,
                                        input logic [opn3d_pkg::HSEED_W-1:0] seed);
      logic [opn3d_pkg::HSEED_W-1:0]   sum;
      logic [2*opn3d_pkg::HSEED_W-1:0] prod;
      sum  = seed + opn3d_pkg::HSEED_W'(idx);
      prod = (2*opn3d_pkg::HSEED_W)'(sum) *
             (2*opn3d_pkg::HSEED_W)'(opn3d_pkg::HASH_MULT[opn3d_pkg::HSEED_W-1:0]);
      return prod[7:0] ^ prod[23:16];
   endfunction

   function automatic logic signed [opn3d_pkg::NOISE_W-1:0] grad(
      input logic [3:0] h, input logic signed [16:0] xv,
      input logic signed [16:0] yv, input logic signed [16:0] zv);
      logic signed [opn3d_pkg::NOISE_W-1:0] u;
      logic signed [opn3d_pkg::NOISE_W-1:0] v;
      logic signed [opn3d_pkg::NOISE_W-1:0] su;
      logic signed [opn3d_pkg::NOISE_W-1:0] sv;
      u = (h < 4'd8) ? opn3d_pkg::NOISE_W'(xv) : opn3d_pkg::NOISE_W'(yv);
      if (h < 4'd4) begin
         v = opn3d_pkg::NOISE_W'(yv);
      end else if (h == 4'd12 || h == 4'd14) begin
         v = opn3d_pkg::NOISE_W'(xv);
      end else begin
         v = opn3d_pkg::NOISE_W'(zv);
      end
      su = h[0] ? -u : u;
      sv = h[1] ? -v : v;
      return su + sv;
   endfunction

   function automatic logic signed [opn3d_pkg::NOISE_W-1:0] blend(
      input logic signed [opn3d_pkg::NOISE_W-1:0] a,
      input logic signed [opn3d_pkg::NOISE_W-1:0] b, input logic [15:0] t);
      logic signed [opn3d_pkg::NOISE_W:0]    d;
      logic signed [opn3d_pkg::NOISE_W+17:0] p;
      d = (opn3d_pkg::NOISE_W+1)'(b) - (opn3d_pkg::NOISE_W+1)'(a);
      p = (opn3d_pkg::NOISE_W+18)'(d) * (opn3d_pkg::NOISE_W+18)'($signed({1'b0, t}));
      return a + $signed(p[opn3d_pkg::NOISE_W+15:16]);
   endfunction

   opn3d_pkg::link_type lk_ff [8];
   opn3d_pkg::link_type out_ff;
   opn3d_pkg::link_type out_in;

   logic [opn3d_pkg::PROD_W-1:0] pin [3];
   logic [7:0]  ci [3];

   logic [7:0]  yi1_in, zi1_in, ha1_in, hb1_in;
   logic [15:0] frac1_in [3];
   logic [31:0] t21_in [3];
   logic [7:0]  yi1_ff, zi1_ff, ha1_ff, hb1_ff;
   logic [15:0] frac1_ff [3];
   logic [31:0] t21_ff [3];

   logic [7:0]  zi2_ff;
   logic [7:0]  h2_in [4];
   logic [7:0]  h2_ff [4];
   logic [15:0] frac2_ff [3];
   logic [15:0] t32_in [3];
   logic [15:0] t32_ff [3];
   logic [19:0] in162_in [3];
   logic [19:0] in162_ff [3];

   logic [7:0]  hc3_in [8];
   logic [7:0]  hc3_ff [8];
   logic [15:0] frac3_ff [3];
   logic [15:0] fade3_in [3];
   logic [15:0] fade3_ff [3];

   logic signed [opn3d_pkg::NOISE_W-1:0] g4_in [8];
   logic signed [opn3d_pkg::NOISE_W-1:0] g4_ff [8];
   logic [15:0] fade4_ff [3];

   logic signed [opn3d_pkg::NOISE_W-1:0] l15_in [4];
   logic signed [opn3d_pkg::NOISE_W-1:0] l15_ff [4];
   logic [15:0] fade5_ff [2];

   logic signed [opn3d_pkg::NOISE_W-1:0] l26_in [2];
   logic signed [opn3d_pkg::NOISE_W-1:0] l26_ff [2];
   logic [15:0] fade6_ff;

   logic signed [opn3d_pkg::NOISE_W-1:0] n7_in, n7_ff;
   logic signed [opn3d_pkg::WPROD_W-1:0] wp8_in, wp8_ff;
   logic [opn3d_pkg::AMP_W-1:0]          amp8_in, amp8_ff;

   assign pin[0] = link_i.px;
   assign pin[1] = link_i.py;
   assign pin[2] = link_i.pz;

   always_comb begin
      logic [47:0] t3f;
      logic [36:0] inner;
      logic [35:0] fp;
      logic signed [16:0] xv, yv, zv;
      logic [2*opn3d_pkg::AMP_W-1:0] ap;
      for (int ax = 0; ax < 3; ax++) begin
         ci[ax]       = pin[ax][opn3d_pkg::FRAC_POS+7:opn3d_pkg::FRAC_POS];
         frac1_in[ax] = pin[ax][opn3d_pkg::FRAC_POS-1:opn3d_pkg::FRAC_POS-16];
         t21_in[ax]   = 32'(frac1_in[ax]) * 32'(frac1_in[ax]);
      end
      yi1_in = ci[1];
      zi1_in = ci[2];
      ha1_in = hash8({2'b00, ci[0]}, link_i.seed);
      hb1_in = hash8({2'b00, ci[0]} + 10'd1, link_i.seed);

      h2_in[0] = hash8({2'b00, ha1_ff} + {2'b00, yi1_ff}, lk_ff[0].seed);
      h2_in[1] = hash8({2'b00, hb1_ff} + {2'b00, yi1_ff}, lk_ff[0].seed);
      h2_in[2] = hash8({2'b00, ha1_ff} + {2'b00, yi1_ff} + 10'd1, lk_ff[0].seed);
      h2_in[3] = hash8({2'b00, hb1_ff} + {2'b00, yi1_ff} + 10'd1, lk_ff[0].seed);
      for (int ax = 0; ax < 3; ax++) begin
         t3f          = 48'(t21_ff[ax]) * 48'(frac1_ff[ax]);
         t32_in[ax]   = t3f[47:32];
         inner        = 37'(t21_ff[ax]) * 37'd6 + (37'd10 << 32)
                        - 37'(frac1_ff[ax]) * 37'(20'd983040);
         in162_in[ax] = inner[35:16];
      end

      for (int k = 0; k < 8; k++) begin
         hc3_in[k] = hash8({2'b00, h2_ff[k % 4]} + {2'b00, zi2_ff} + ((k >= 4) ? 10'd1 : 10'd0),
                           lk_ff[1].seed);
      end
      for (int ax = 0; ax < 3; ax++) begin
         fp           = 36'(t32_ff[ax]) * 36'(in162_ff[ax]);
         fade3_in[ax] = fp[31:16];
      end

      for (int k = 0; k < 8; k++) begin
         xv = ((k & 1) != 0) ? 17'($signed({1'b0, frac3_ff[0]}) - $signed(opn3d_pkg::ONE_Q16))
                             : $signed({1'b0, frac3_ff[0]});
         yv = ((k & 2) != 0) ? 17'($signed({1'b0, frac3_ff[1]}) - $signed(opn3d_pkg::ONE_Q16))
                             : $signed({1'b0, frac3_ff[1]});
         zv = ((k & 4) != 0) ? 17'($signed({1'b0, frac3_ff[2]}) - $signed(opn3d_pkg::ONE_Q16))
                             : $signed({1'b0, frac3_ff[2]});
         g4_in[k] = grad(hc3_ff[k][3:0], xv, yv, zv);
      end

      for (int j = 0; j < 4; j++) begin
         l15_in[j] = blend(g4_ff[2*j], g4_ff[2*j+1], fade4_ff[0]);
      end
      for (int j = 0; j < 2; j++) begin
         l26_in[j] = blend(l15_ff[2*j], l15_ff[2*j+1], fade5_ff[0]);
      end
      n7_in = blend(l26_ff[0], l26_ff[1], fade6_ff);

      wp8_in  = opn3d_pkg::WPROD_W'(n7_ff) *
                opn3d_pkg::WPROD_W'($signed({1'b0, lk_ff[6].amp}));
      ap      = (2*opn3d_pkg::AMP_W)'(lk_ff[6].amp) * (2*opn3d_pkg::AMP_W)'(persistence);
      amp8_in = ap[opn3d_pkg::AMP_W+15:16];

      out_in      = lk_ff[7];
      out_in.px   = {lk_ff[7].px[opn3d_pkg::PROD_W-2:0], 1'b0};
      out_in.py   = {lk_ff[7].py[opn3d_pkg::PROD_W-2:0], 1'b0};
      out_in.pz   = {lk_ff[7].pz[opn3d_pkg::PROD_W-2:0], 1'b0};
      out_in.seed = lk_ff[7].seed + opn3d_pkg::HSEED_W'(1);
      out_in.amp  = amp8_ff;
      if (lk_ff[7].cnt != '0) begin
         out_in.cnt     = lk_ff[7].cnt - opn3d_pkg::CNT_W'(1);
         out_in.total   = lk_ff[7].total + opn3d_pkg::TOTAL_W'(wp8_ff);
         out_in.amp_sum = lk_ff[7].amp_sum + opn3d_pkg::ASUM_W'(lk_ff[7].amp);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < 8; s++) begin
            lk_ff[s].valid <= 1'b0;
         end
         out_ff.valid <= 1'b0;
      end else if (en) begin
         lk_ff[0] <= link_i;
         for (int s = 1; s < 8; s++) begin
            lk_ff[s] <= lk_ff[s-1];
         end
         out_ff <= out_in;
      end
      if (en) begin
         yi1_ff   <= yi1_in;
         zi1_ff   <= zi1_in;
         ha1_ff   <= ha1_in;
         hb1_ff   <= hb1_in;
         frac1_ff <= frac1_in;
         t21_ff   <= t21_in;
         zi2_ff   <= zi1_ff;
         h2_ff    <= h2_in;
         frac2_ff <= frac1_ff;
         t32_ff   <= t32_in;
         in162_ff <= in162_in;
         hc3_ff   <= hc3_in;
         frac3_ff <= frac2_ff;
         fade3_ff <= fade3_in;
         g4_ff    <= g4_in;
         fade4_ff <= fade3_ff;
         l15_ff   <= l15_in;
         fade5_ff[0] <= fade4_ff[1];
         fade5_ff[1] <= fade4_ff[2];
         l26_ff   <= l26_in;
         fade6_ff <= fade5_ff[1];
         n7_ff    <= n7_in;
         wp8_ff   <= wp8_in;
         amp8_ff  <= amp8_in;
      end
   end

   assign link_o = out_ff;

endmodule

>>> rtl/opn3d_div.sv
// ----------------------------------------------------------------------------
// Normalizing divider
// Divides the weighted octave sum by four times the amplitude sum, rounding
// toward zero, one quotient bit per stage, then saturates to Q2.14.
// ----------------------------------------------------------------------------
module opn3d_div (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   en,
   input  logic                                   in_valid,
   input  logic signed [opn3d_pkg::TOTAL_W-1:0]   in_total,
   input  logic [opn3d_pkg::ASUM_W-1:0]           in_amp_sum,
   output logic                                   out_valid,
   output logic [opn3d_pkg::OUT_W-1:0]            out_value
);

   localparam int DEN_W = opn3d_pkg::ASUM_W + 2;
   localparam int CMP_W = opn3d_pkg::TOTAL_W + DEN_W;

   logic                              vld_ff [opn3d_pkg::QUO_W+1];
   logic                              neg_ff [opn3d_pkg::QUO_W+1];
   logic [opn3d_pkg::TOTAL_W-1:0]     rem_ff [opn3d_pkg::QUO_W+1];
   logic [DEN_W-1:0]                  den_ff [opn3d_pkg::QUO_W+1];
   logic [opn3d_pkg::QUO_W-1:0]       quo_ff [opn3d_pkg::QUO_W+1];
   logic [CMP_W-1:0]                  trial  [opn3d_pkg::QUO_W];
   logic                              ge     [opn3d_pkg::QUO_W];
   logic                              out_valid_ff;
   logic [opn3d_pkg::OUT_W-1:0]       out_value_ff, out_value_in;
   logic [opn3d_pkg::QUO_W-1:0]       mag;

   always_comb begin
      for (int k = 0; k < opn3d_pkg::QUO_W; k++) begin
         trial[k] = CMP_W'(rem_ff[k]) - (CMP_W'(den_ff[k]) << (opn3d_pkg::QUO_W - 1 - k));
         ge[k]    = !trial[k][CMP_W-1];
      end
      mag = quo_ff[opn3d_pkg::QUO_W];
      if (neg_ff[opn3d_pkg::QUO_W]) begin
         out_value_in = (mag > opn3d_pkg::SAT_NEG_MAG) ? opn3d_pkg::SAT_NEG
                                                       : -opn3d_pkg::OUT_W'(mag);
      end else begin
         out_value_in = (mag > opn3d_pkg::SAT_POS_MAG) ? opn3d_pkg::SAT_POS
                                                       : opn3d_pkg::OUT_W'(mag);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= opn3d_pkg::QUO_W; k++) begin
            vld_ff[k] <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
         for (int k = 0; k < opn3d_pkg::QUO_W; k++) begin
            vld_ff[k+1] <= vld_ff[k];
         end
         out_valid_ff <= vld_ff[opn3d_pkg::QUO_W];
      end
      if (en) begin
         neg_ff[0] <= in_total[opn3d_pkg::TOTAL_W-1];
         rem_ff[0] <= in_total[opn3d_pkg::TOTAL_W-1] ? -in_total : in_total;
         den_ff[0] <= {in_amp_sum, 2'b00};
         quo_ff[0] <= '0;
         for (int k = 0; k < opn3d_pkg::QUO_W; k++) begin
            neg_ff[k+1] <= neg_ff[k];
            den_ff[k+1] <= den_ff[k];
            rem_ff[k+1] <= ge[k] ? trial[k][opn3d_pkg::TOTAL_W-1:0] : rem_ff[k];
            quo_ff[k+1] <= quo_ff[k] |
                           (opn3d_pkg::QUO_W'(ge[k]) << (opn3d_pkg::QUO_W - 1 - k));
         end
         out_value_ff <= out_value_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_value = out_value_ff;

endmodule

>>> rtl/opn3d_checker.sv
// ----------------------------------------------------------------------------
// Octave Perlin noise port checker
// Watches the stream ports of the core and is bound to the top level.
// ----------------------------------------------------------------------------
`include "octave_perlin_noise_3d_core_assert.svh"

module opn3d_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tready,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [opn3d_pkg::OUT_W-1:0]  rsp_tdata
);

   `OPN3D_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "rsp_tvalid dropped")
   `OPN3D_ASSERT(a_rsp_stable, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata), "rsp_tdata changed")
   `OPN3D_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_tvalid, "result after reset")
   `OPN3D_ASSERT(a_stall_full, !req_tready |-> rsp_tvalid, "input stalled with no result waiting")
   `OPN3D_ASSERT(a_stall_cause, $fell(req_tready) |-> $past(rsp_tvalid && !rsp_tready), "stall without blocked transfer")

endmodule

bind octave_perlin_noise_3d_core opn3d_checker u_opn3d_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Octave Perlin noise core testbench
// Streams points through the core across several register settings and
// handshake pressure phases, and checks every noise value against a
// bit-exact fixed-point predictor held in a small scoreboard class.
// ----------------------------------------------------------------------------
module tb;

   class noise_scoreboard;
      logic [31:0] seed;
      logic [3:0]  octaves;
      logic [16:0] pers;
      logic [31:0] freq;
      logic [15:0] expected_noise[$];
      int          errors;

      function new();
         seed     = opn3d_pkg::SEED_RST;
         octaves  = opn3d_pkg::OCT_RST;
         pers     = opn3d_pkg::PERS_RST;
         freq     = opn3d_pkg::BASE_FREQ_RST;
         errors   = 0;
      endfunction

      function void set_reg(logic [opn3d_pkg::CSR_IDX_W-1:0] idx, logic [31:0] value);
         case (idx)
            opn3d_pkg::CSR_NOISE_SEED: begin
               seed = value;
            end
            opn3d_pkg::CSR_OCTAVE_COUNT: begin
               octaves = value[3:0];
            end
            opn3d_pkg::CSR_PERSISTENCE: begin
               pers = value[16:0];
            end
            opn3d_pkg::CSR_BASE_FREQUENCY: begin
               freq = value;
            end
            default: begin
            end
         endcase
      endfunction

      function logic [31:0] hash8(logic [31:0] idx, logic [31:0] s);
         logic [31:0] v;
         v = ((idx + s) * opn3d_pkg::HASH_MULT) & 32'h7FFF_FFFF;
         v = (v ^ (v >> 16)) & 32'hFF;
         return v;
      endfunction

      function longint fade(longint t);
         longint inner;
         longint t3;
         inner = 6 * t * t - 15 * t * 65536 + (longint'(10) <<< 32);
         inner = inner >> 16;
         t3    = (t * t * t) >> 32;
         return (t3 * inner) >> 16;
      endfunction

      function longint lerp(longint a, longint b, longint t);
         return a + ((t * (b - a)) >>> 16);
      endfunction

      function longint grad(logic [31:0] h, longint x, longint y, longint z);
         logic [3:0] g;
         longint     u;
         longint     v;
         g = h[3:0];
         u = (g < 8) ? x : y;
         v = (g < 4) ? y : ((g == 12 || g == 14) ? x : z);
         return ((g[0]) ? -u : u) + ((g[1]) ? -v : v);
      endfunction

      function void split(logic [31:0] c, int oct, output logic [31:0] cell_idx,
                          output longint frac);
         logic [63:0] p;
         p        = {{32{c[31]}}, c} * {32'd0, freq};
         p        = p << oct;
         cell_idx = {24'd0, p[47:40]};
         frac     = longint'(p[39:24]);
      endfunction

      function longint octave_value(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                                    int oct, logic [31:0] s);
         logic [31:0] xi, yi, zi, a, b, aa, ab, ba, bb;
         longint      xf, yf, zf, xg, yg, zg, u, v, w, x1, x2, x3, x4, y1, y2;
         split(cx, oct, xi, xf);
         split(cy, oct, yi, yf);
         split(cz, oct, zi, zf);
         xg = xf - 65536;
         yg = yf - 65536;
         zg = zf - 65536;
         u  = fade(xf);
         v  = fade(yf);
         w  = fade(zf);
         a  = hash8(xi, s);
         b  = hash8(xi + 1, s);
         aa = hash8(a + yi, s);
         ab = hash8(a + yi + 1, s);
         ba = hash8(b + yi, s);
         bb = hash8(b + yi + 1, s);
         x1 = lerp(grad(hash8(aa + zi, s), xf, yf, zf),
                   grad(hash8(ba + zi, s), xg, yf, zf), u);
         x2 = lerp(grad(hash8(ab + zi, s), xf, yg, zf),
                   grad(hash8(bb + zi, s), xg, yg, zf), u);
         y1 = lerp(x1, x2, v);
         x3 = lerp(grad(hash8(aa + zi + 1, s), xf, yf, zg),
                   grad(hash8(ba + zi + 1, s), xg, yf, zg), u);
         x4 = lerp(grad(hash8(ab + zi + 1, s), xf, yg, zg),
                   grad(hash8(bb + zi + 1, s), xg, yg, zg), u);
         y2 = lerp(x3, x4, v);
         return lerp(y1, y2, w);
      endfunction

      function void note_point(logic [95:0] data);
         int     n;
         longint total, amp_sum, amp, q;
         n       = octaves;
         total   = 0;
         amp_sum = 0;
         amp     = 65536;
         if (n == 0) n = 1;
         if (n > opn3d_pkg::MAX_OCTAVES) n = opn3d_pkg::MAX_OCTAVES;
         for (int i = 0; i < n; i++) begin
            total   += octave_value(data[31:0], data[63:32], data[95:64], i,
                                    seed + 32'(i)) * amp;
            amp_sum += amp;
            amp      = (amp * longint'(pers)) >> 16;
         end
         q = total / (amp_sum * 4);
         if (q > 32767) q = 32767;
         if (q < -32768) q = -32768;
         expected_noise.push_back(q[15:0]);
      endfunction

      function void check_noise(logic [15:0] actual);
         logic [15:0] want;
         if (expected_noise.size() == 0) begin
            $display("%0t: unexpected noise value %h", $time, actual);
            errors++;
         end else begin
            want = expected_noise.pop_front();
            if (actual !== want) begin
               $display("%0t: noise_value expected %h actual %h", $time, want, actual);
               errors++;
            end
         end
      endfunction
   endclass

   logic                             clock;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [95:0]                      req_tdata;
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [opn3d_pkg::OUT_W-1:0]      rsp_tdata;
   logic                             csr_wen;
   logic [opn3d_pkg::CSR_IDX_W-1:0]  csr_addr;
   logic [opn3d_pkg::CSR_DATA_W-1:0] csr_wdata;

   noise_scoreboard sb;
   int              send_idle_pct;
   int              recv_stall_pct;

   octave_perlin_noise_3d_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      #5000000;
      $display("tb NOT OK");
      $finish;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_noise(rsp_tdata);
      end
   end

   task automatic send_point(logic [95:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      sb.note_point(data);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.expected_noise.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic write_regs(logic [31:0] s, logic [31:0] o, logic [31:0] p,
                             logic [31:0] f);
      logic [31:0] vals[4];
      vals = '{s, o, p, f};
      for (int i = 0; i < 4; i++) begin
         csr_wen   <= 1'b1;
         csr_addr  <= opn3d_pkg::CSR_IDX_W'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
         sb.set_reg(opn3d_pkg::CSR_IDX_W'(i), vals[i]);
      end
      csr_wen <= 1'b0;
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(2097152)) - 1048576);
         2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
         default: return $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(3)
                                           : 32'h8000_0000 + $urandom_range(3);
      endcase
   endfunction

   initial begin
      logic [31:0] corner[8];
      sb             = new();
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      rsp_tready     = 1'b0;
      csr_wen        = 1'b0;
      csr_addr       = '0;
      csr_wdata      = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      corner = '{32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h0000_FFFF, 32'h0001_0000, 32'h0000_8000, 32'hFF00_0001};
      for (int i = 0; i < 8; i++) begin
         send_point({corner[(i + 2) % 8], corner[(i + 1) % 8], corner[i]});
      end
      for (int i = 0; i < 8; i++) begin
         send_point({corner[i], corner[i], corner[i]});
      end

      for (int ph = 0; ph < 8; ph++) begin
         drain();
         case (ph)
            0: write_regs(32'h7FFF_FFFF, 0, 0, 32'hFFFF_FFFF);
            1: write_regs(32'h8000_0000, 15, 17'h1FFFF, 0);
            2: write_regs($urandom, 8, 65536, 32'h0100_0000);
            3: write_regs($urandom, 1, $urandom_range(131071), $urandom);
            4: write_regs(0, 4, 32768, 32'h0100_0000);
            default: write_regs($urandom, $urandom_range(15), $urandom_range(131071),
                                $urandom_range(1) ? $urandom : $urandom_range(67108864));
         endcase
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
            default: begin send_idle_pct = 14; recv_stall_pct = 14; end
         endcase
         if (ph < 6) begin
            send_point({corner[3], corner[2], corner[0]});
            send_point({corner[1], corner[4], corner[5]});
         end
         for (int k = 0; k < 120; k++) begin
            send_point({rand_coord(), rand_coord(), rand_coord()});
         end
      end

      drain();
      if (sb.expected_noise.size() != 0) sb.errors++;
      if (sb.errors == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end
endmodule
